@@ sv/perceptron_trainer_defines.svh @@
// ---------------------------------------------------------------------------
// Perceptron trainer assertion macros
// Shared property shorthands for the checks in the perceptron trainer.
// ---------------------------------------------------------------------------
`ifndef PERCEPTRON_TRAINER_DEFINES_SVH
`define PERCEPTRON_TRAINER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PT_ASSERT_IMPLIES(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PT_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ sv/pt_pkg.sv @@
// ---------------------------------------------------------------------------
// Perceptron trainer package
// Word types, command and register codes and sizing constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pt_pkg;

	localparam int unsigned MAX_SAMPLES_DEF  = 256;
	localparam int unsigned MAX_FEATURES_DEF = 8;

	// Accumulator width covers up to 255 products of 48 bits plus the bias term.
	localparam int unsigned ACC_W  = 56;
	localparam int unsigned PASS_W = 17;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_TRAIN    = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	localparam logic [1:0] CFG_FEATURE_COUNT = 2'd0;
	localparam logic [1:0] CFG_LEARN_RATE    = 2'd1;
	localparam logic [1:0] CFG_MAX_PASSES    = 2'd2;

	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_CLASS  = 1'b1;

	typedef struct packed {
		logic [1:0]          command;
		logic signed [15:0]  feature_value;
		logic                label_positive;
	} in_word_t;

	typedef struct packed {
		logic                kind;
		logic signed [31:0]  weight_value;
		logic                class_positive;
		logic                converged;
		logic                last;
	} out_word_t;

	typedef struct packed {
		logic [3:0]  feature_count;
		logic [15:0] learn_rate;
		logic [15:0] max_passes;
	} cfg_t;

	// Decoded operation as it sits in the queue.
	typedef struct packed {
		logic                is_load;
		logic                is_train;
		logic                is_classify;
		logic                is_clear;
		logic signed [15:0]  x;
		logic                label;
	} entry_t;

	typedef struct packed {
		logic training;
		logic pipe_busy;
	} status_t;

endpackage

`default_nettype wire

@@ sv/pt_front.sv @@
// ---------------------------------------------------------------------------
// Perceptron trainer front end
// Accepts sample words, decodes the command and hands them to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pt_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_stall,
	input  wire pt_pkg::in_word_t sample_word,
	output logic                  push,
	output pt_pkg::entry_t        entry,
	input  wire logic             full
);
	import pt_pkg::*;

	logic   v_s1;
	entry_t e_s1;
	logic   accept;

	assign push         = v_s1 && !full;
	assign sample_stall = v_s1 && full;
	assign accept       = sample_valid && !sample_stall;
	assign entry        = e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_s1.is_load     <= (sample_word.command == CMD_LOAD);
			e_s1.is_train    <= (sample_word.command == CMD_TRAIN);
			e_s1.is_classify <= (sample_word.command == CMD_CLASSIFY);
			e_s1.is_clear    <= (sample_word.command == CMD_CLEAR);
			e_s1.x           <= sample_word.feature_value;
			e_s1.label       <= sample_word.label_positive;
		end
	end

endmodule

`default_nettype wire

@@ sv/pt_queue.sv @@
// ---------------------------------------------------------------------------
// Perceptron trainer operation queue
// Short FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pt_pkg::entry_t push_entry,
	output logic                full,
	output logic                q_valid,
	output pt_pkg::entry_t      q_entry,
	input  wire logic           q_pop
);
	import pt_pkg::*;

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	entry_t          slot_q [0:QUEUE_DEPTH-1];
	logic [IW-1:0]   wp_q;
	logic [IW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_entry = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

@@ sv/pt_back.sv @@
// ---------------------------------------------------------------------------
// Perceptron trainer back end
// Sample store, weights, classification pipe and the training sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pt_back #(
	parameter int unsigned MAX_SAMPLES  = pt_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned MAX_FEATURES = pt_pkg::MAX_FEATURES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pt_pkg::cfg_t   cfg,
	input  wire logic           q_valid,
	input  wire pt_pkg::entry_t q_entry,
	output logic                q_pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output pt_pkg::out_word_t   result_word,
	output pt_pkg::status_t     status
);
	import pt_pkg::*;

	localparam int unsigned SW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned PW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int unsigned WIW  = $clog2(MAX_FEATURES + 1);
	localparam int unsigned AW   = SW + PW;
	localparam int unsigned MEM_DEPTH = MAX_SAMPLES << PW;
	localparam logic [WIW-1:0] BIAS_IDX = WIW'(MAX_FEATURES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_UPD    = 3'd4;
	localparam logic [2:0] ST_UDRAIN = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	localparam logic [1:0] PK_SCAN = 2'd0;
	localparam logic [1:0] PK_UPD  = 2'd1;
	localparam logic [1:0] PK_CLS  = 2'd2;

	localparam logic signed [48:0] W_MAX = 49'sh0_0000_7FFF_FFFF;
	localparam logic signed [48:0] W_MIN = {{17{1'b1}}, 32'h8000_0000};

	function automatic logic signed [31:0] sat32(input logic signed [48:0] t);
		logic signed [31:0] r;
		if (t > W_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (t < W_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = t[31:0];
		end
		return r;
	endfunction

	// Stores
	logic signed [15:0] smem [0:MEM_DEPTH-1];
	logic               lmem [0:MAX_SAMPLES-1];
	logic signed [15:0] mem_rd_q;
	logic               lab_rd_q;
	logic [AW-1:0]      mem_ra;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic               lab_we;

	// Weights, bias at the top index
	logic signed [31:0] w_q [0:MAX_FEATURES];
	logic [WIW-1:0]     widx;
	logic signed [31:0] w_rd;

	logic [CNTW-1:0]    count_q;
	logic [PW-1:0]      pos_q;
	logic signed [ACC_W-1:0] csum_q;

	logic [2:0]         state_q;
	logic [CNTW-1:0]    s_q;
	logic [WIW-1:0]     j_q;
	logic [WIW-1:0]     e_q;
	logic [PASS_W-1:0]  pass_q;
	logic               conv_q;
	logic signed [ACC_W-1:0] acc_q;

	// Shared multiplier pipe
	logic               v_s1;
	logic [1:0]         kind_s1;
	logic [WIW-1:0]     idx_s1;
	logic signed [15:0] x_s1;
	logic               final_s1;
	logic               v_s2;
	logic [1:0]         kind_s2;
	logic [WIW-1:0]     idx_s2;
	logic               final_s2;
	logic signed [47:0] prod_s2;

	logic               out_valid_q;
	out_word_t          out_q;
	logic               out_free;

	// Effective feature count and shared position
	logic [6:0]         fc_raw;
	logic [WIW-1:0]     fc;
	logic [PW-1:0]      pos_c;
	logic [WIW:0]       pos_nx;
	logic               pos_last;
	logic [WIW:0]       j_nx;
	logic               j_last;

	logic signed [32:0] mul_a;
	logic signed [15:0] mul_x;
	logic signed [48:0] mul_p;

	logic signed [ACC_W-1:0] bias_acc;
	logic signed [ACC_W-1:0] csum_nx;
	logic signed [ACC_W-1:0] cls_v;
	logic signed [48:0]      upd_d;
	logic signed [48:0]      upd_t;
	logic signed [48:0]      bias_t;
	logic signed [48:0]      bias_step;
	logic                    pipe_empty;
	logic                    mistake;
	logic [PASS_W-1:0]       pass_nx;
	logic                    ok_pop;
	logic                    cls_write;
	logic                    emit_write;

	assign fc_raw = {3'b000, cfg.feature_count};
	assign fc = (fc_raw == 7'd0) ? WIW'(1) :
		(fc_raw > 7'(MAX_FEATURES)) ? WIW'(MAX_FEATURES) : WIW'(fc_raw);

	assign pos_c    = (WIW'(pos_q) >= fc) ? PW'(fc - 1'b1) : pos_q;
	assign pos_nx   = (WIW + 1)'(pos_c) + 1'b1;
	assign pos_last = (pos_nx >= (WIW + 1)'(fc));
	assign j_nx     = (WIW + 1)'(j_q) + 1'b1;
	assign j_last   = (j_nx >= (WIW + 1)'(fc));

	assign pipe_empty = !v_s1 && !v_s2;
	assign out_free   = !out_valid_q || !result_stall;

	// One weight read port, its index chosen by what the sequencer is doing.
	always_comb begin
		case (state_q)
			ST_UPD, ST_UDRAIN: widx = idx_s2;
			ST_EMIT:           widx = (e_q == fc) ? BIAS_IDX : e_q;
			default:           widx = idx_s1;
		endcase
	end
	assign w_rd = w_q[widx];

	assign mul_a = (kind_s1 == PK_UPD) ? $signed({17'b0, cfg.learn_rate}) : 33'(w_rd);
	assign mul_x = (kind_s1 == PK_CLS) ? x_s1 : mem_rd_q;
	assign mul_p = mul_a * mul_x;

	assign bias_acc = $signed({{(ACC_W - 40){w_q[MAX_FEATURES][31]}}, w_q[MAX_FEATURES], 8'b0});
	assign csum_nx  = csum_q + ACC_W'(prod_s2);
	assign cls_v    = csum_nx + bias_acc;

	assign upd_d     = lab_rd_q ? 49'(prod_s2) : -49'(prod_s2);
	assign upd_t     = 49'(w_rd) + upd_d;
	assign bias_step = $signed({25'b0, cfg.learn_rate, 8'b0});
	assign bias_t    = lab_rd_q ? (49'(w_q[MAX_FEATURES]) + bias_step)
		: (49'(w_q[MAX_FEATURES]) - bias_step);

	assign mistake = lab_rd_q ? (acc_q[ACC_W-1] || acc_q == '0) : !acc_q[ACC_W-1];
	assign pass_nx = pass_q + 1'b1;

	always_comb begin
		ok_pop = 1'b0;
		if (q_entry.is_load) begin
			ok_pop = 1'b1;
		end else if (q_entry.is_classify) begin
			ok_pop = !pos_last || (!(v_s1 && final_s1) && !(v_s2 && final_s2) && out_free);
		end else begin
			ok_pop = pipe_empty;
		end
	end
	assign q_pop = q_valid && (state_q == ST_IDLE) && ok_pop;

	assign cls_write  = v_s2 && (kind_s2 == PK_CLS) && final_s2;
	assign emit_write = (state_q == ST_EMIT) && out_free;

	// Store ports
	assign mem_we = q_pop && q_entry.is_load && (count_q < CNTW'(MAX_SAMPLES));
	assign mem_wa = {count_q[SW-1:0], pos_c};
	assign lab_we = mem_we && pos_last;
	assign mem_ra = {s_q[SW-1:0], j_q[PW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			smem[mem_wa] <= q_entry.x;
		end
		if (lab_we) begin
			lmem[count_q[SW-1:0]] <= q_entry.label;
		end
		mem_rd_q <= smem[mem_ra];
		lab_rd_q <= lmem[s_q[SW-1:0]];
	end

	// Multiplier pipe payload
	always_ff @(posedge clk) begin
		prod_s2 <= mul_p[47:0];
		idx_s2  <= idx_s1;
		kind_s2 <= kind_s1;
		final_s2 <= final_s1;
		if (q_pop && q_entry.is_classify) begin
			kind_s1  <= PK_CLS;
			idx_s1   <= WIW'(pos_c);
			x_s1     <= q_entry.x;
			final_s1 <= pos_last;
		end else begin
			kind_s1  <= (state_q == ST_UPD) ? PK_UPD : PK_SCAN;
			idx_s1   <= j_q;
			final_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			count_q <= '0;
			pos_q   <= '0;
			csum_q  <= '0;
			s_q     <= '0;
			j_q     <= '0;
			e_q     <= '0;
			pass_q  <= '0;
			conv_q  <= 1'b0;
			acc_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= MAX_FEATURES; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			v_s1 <= (q_pop && q_entry.is_classify) ||
				state_q == ST_SCAN || state_q == ST_UPD;
			v_s2 <= v_s1;

			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cls_write || emit_write) begin
				out_valid_q <= 1'b1;
			end

			// Second pipe stage: accumulate a scan sum, update a weight or add to the classify sum.
			if (v_s2) begin
				case (kind_s2)
					PK_SCAN: acc_q <= acc_q + ACC_W'(prod_s2);
					PK_UPD:  w_q[idx_s2] <= sat32(upd_t);
					PK_CLS:  csum_q <= final_s2 ? '0 : csum_nx;
					default: acc_q <= acc_q;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_entry.is_load) begin
							if (mem_we) begin
								if (pos_last) begin
									count_q <= count_q + 1'b1;
									pos_q   <= '0;
								end else begin
									pos_q <= PW'(pos_nx);
								end
							end
						end else if (q_entry.is_classify) begin
							pos_q <= pos_last ? '0 : PW'(pos_nx);
						end else if (q_entry.is_clear) begin
							count_q <= '0;
							pos_q   <= '0;
							csum_q  <= '0;
						end else begin
							pos_q   <= '0;
							csum_q  <= '0;
							pass_q  <= '0;
							s_q     <= '0;
							for (int i = 0; i <= MAX_FEATURES; i++) begin
								w_q[i] <= '0;
							end
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (s_q >= count_q) begin
						conv_q  <= 1'b1;
						e_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						acc_q   <= bias_acc;
						j_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						if (mistake) begin
							j_q     <= '0;
							state_q <= ST_UPD;
						end else begin
							s_q     <= s_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_UPD: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						state_q <= ST_UDRAIN;
					end
				end
				ST_UDRAIN: begin
					if (pipe_empty) begin
						w_q[MAX_FEATURES] <= sat32(bias_t);
						pass_q <= pass_nx;
						if (pass_nx <= {1'b0, cfg.max_passes}) begin
							s_q     <= '0;
							state_q <= ST_START;
						end else begin
							conv_q  <= 1'b0;
							e_q     <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						e_q <= e_q + 1'b1;
						if (e_q == fc) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cls_write) begin
			out_q.kind           <= KIND_CLASS;
			out_q.weight_value   <= '0;
			out_q.class_positive <= !cls_v[ACC_W-1];
			out_q.converged      <= 1'b0;
			out_q.last           <= 1'b1;
		end else if (emit_write) begin
			out_q.kind           <= KIND_WEIGHT;
			out_q.weight_value   <= w_rd;
			out_q.class_positive <= 1'b0;
			out_q.converged      <= conv_q;
			out_q.last           <= (e_q == fc);
		end
	end

	assign result_valid     = out_valid_q;
	assign result_word      = out_q;
	assign status.training  = (state_q != ST_IDLE);
	assign status.pipe_busy = !pipe_empty;

endmodule

`default_nettype wire

@@ sv/perceptron_trainer.sv @@
// A load word passes the front-end register and the queue before it reaches the store; a
// classify result also passes both multiplier pipe stages and the output register. One load
// or classify word per cycle while the sequencer is idle, but a final classify word waits
// until the earlier result has left the output. Per pass, a train word starts, scans and
// drains each sample, updating and draining again on a mistake, then emits weights and bias.
// Reset is asynchronous; weights clear at once, sample stores need no clearing.
// ---------------------------------------------------------------------------
// Perceptron trainer top level
// Fixed-point perceptron with an on-chip sample store and training sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "perceptron_trainer_defines.svh"

module perceptron_trainer #(
	parameter int unsigned MAX_SAMPLES  = pt_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned MAX_FEATURES = pt_pkg::MAX_FEATURES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire pt_pkg::in_word_t  sample_word,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output pt_pkg::out_word_t      result_word,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import pt_pkg::*;

	// The configuration registers hold their reset defaults until written. Writes
	// to an index beyond the three registers are dropped.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feature_count <= 4'd2;
			cfg_q.learn_rate    <= 16'd256;
			cfg_q.max_passes    <= 16'd100;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FEATURE_COUNT: cfg_q.feature_count <= cfg_data[3:0];
				CFG_LEARN_RATE:    cfg_q.learn_rate    <= cfg_data;
				CFG_MAX_PASSES:    cfg_q.max_passes    <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// The front end registers each accepted word and decodes its command; the
	// queue lets words keep arriving while the back end is busy training or
	// waiting on the output.
	logic    push;
	logic    full;
	entry_t  push_entry;
	logic    q_valid;
	entry_t  q_entry;
	logic    q_pop;
	status_t status;

	pt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_word  (sample_word),
		.push         (push),
		.entry        (push_entry),
		.full         (full)
	);

	pt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop)
	);

	// The back end owns all learning state. Load words go straight into the sample store
	// and classify words run through the shared multiplier pipe; a train word hands control
	// to the sequencer, which scans the samples, updates on the first mistake
	// and finally streams the weights and bias out through the output register.
	pt_back #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.MAX_FEATURES (MAX_FEATURES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.status       (status)
	);

	// A classification word carries no weight and always closes its run.
	`PT_ASSERT_IMPLIES(a_cls_shape, result_valid && result_word.kind == KIND_CLASS, result_word.weight_value == 32'sd0 && !result_word.converged && result_word.last, "classify word malformed")
	// Training words never carry a class bit.
	`PT_ASSERT_IMPLIES(a_wt_shape, result_valid && result_word.kind == KIND_WEIGHT, !result_word.class_positive, "weight word has class bit")
	// While the sequencer runs with the multiplier pipe idle, no queued word is taken.
	`PT_ASSERT_IMPLIES(a_train_hold, status.training && !status.pipe_busy, !q_pop, "queue popped during training")

endmodule

`default_nettype wire

@@ tb/sv/perceptron_trainer_tb.sv @@
// ---------------------------------------------------------------------------
// Perceptron trainer regression bench
// Drives load, train, classify and clear words into the trainer and checks
// every weight, bias and classification word against a behavioral predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module perceptron_trainer_tb;
	import pt_pkg::*;

	localparam int NSAMP = 256;
	localparam int NFEAT = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 70;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      sample_valid = 1'b0;
	logic      sample_stall;
	in_word_t  sample_word = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result_word;
	logic      cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	perceptron_trainer uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.sample_word(sample_word),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_word(result_word),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the trainer state, kept up to date as words are accepted.
	logic [3:0]  sh_feature_count = 4'd2;
	logic [15:0] sh_learn_rate = 16'd256;
	logic [15:0] sh_max_passes = 16'd100;
	logic signed [15:0] sh_store [NSAMP][NFEAT];
	bit          sh_written [NSAMP][NFEAT];
	bit          sh_label [NSAMP];
	logic signed [31:0] sh_weight [NFEAT+1];
	int          sh_count = 0;
	int          sh_pos = 0;
	longint      sh_csum = 0;

	out_word_t pending_words [$];
	int  errors = 0;
	int  cycles = 0;
	int  train_runs = 0;
	int  class_results = 0;
	int  words_sent = 0;
	bit  quiet = 1'b0;

	function automatic int active_features();
		if (sh_feature_count == 0) return 1;
		if (sh_feature_count > NFEAT) return NFEAT;
		return int'(sh_feature_count);
	endfunction

	function automatic logic signed [31:0] sat_add32(logic signed [31:0] w, longint d);
		longint t;
		t = longint'(w) + d;
		if (t > 64'sd2147483647) return 32'sh7fffffff;
		if (t < -64'sd2147483648) return 32'sh80000000;
		return t[31:0];
	endfunction

	// Runs the pass loop on the shadow store; returns the converged flag.
	function automatic bit fit_weights(int nf);
		int passes;
		bit mistake;
		longint sum;
		longint step;
		for (int j = 0; j <= NFEAT; j++) sh_weight[j] = '0;
		passes = 0;
		do begin
			mistake = 1'b0;
			for (int s = 0; s < sh_count && !mistake; s++) begin
				sum = longint'(sh_weight[NFEAT]) * 256;
				for (int j = 0; j < nf; j++)
					sum += longint'(sh_weight[j]) * longint'(sh_store[s][j]);
				if (sh_label[s] ? (sum <= 0) : (sum >= 0)) begin
					for (int j = 0; j < nf; j++) begin
						step = longint'(sh_learn_rate) * longint'(sh_store[s][j]);
						sh_weight[j] = sat_add32(sh_weight[j], sh_label[s] ? step : -step);
					end
					step = longint'(sh_learn_rate) * 256;
					sh_weight[NFEAT] = sat_add32(sh_weight[NFEAT],
						sh_label[s] ? step : -step);
					mistake = 1'b1;
				end
			end
			passes++;
		end while (passes <= int'(sh_max_passes) && mistake);
		return !mistake;
	endfunction

	// Updates the shadow state for one accepted word and queues its results.
	task automatic predict_word(in_word_t w);
		int nf;
		bit conv;
		out_word_t ow;
		longint v;
		nf = active_features();
		case (w.command)
			CMD_LOAD: begin
				if (sh_count < NSAMP) begin
					if (sh_pos >= nf) sh_pos = nf - 1;
					sh_store[sh_count][sh_pos] = w.feature_value;
					sh_written[sh_count][sh_pos] = 1'b1;
					sh_pos++;
					if (sh_pos >= nf) begin
						sh_label[sh_count] = w.label_positive;
						sh_count++;
						sh_pos = 0;
					end
				end
			end
			CMD_TRAIN: begin
				sh_pos = 0;
				sh_csum = 0;
				conv = fit_weights(nf);
				train_runs++;
				for (int j = 0; j <= nf; j++) begin
					ow = '0;
					ow.kind = KIND_WEIGHT;
					ow.weight_value = (j == nf) ? sh_weight[NFEAT] : sh_weight[j];
					ow.converged = conv;
					ow.last = (j == nf);
					pending_words.push_back(ow);
				end
			end
			CMD_CLASSIFY: begin
				if (sh_pos >= nf) sh_pos = nf - 1;
				sh_csum += longint'(sh_weight[sh_pos]) * longint'(w.feature_value);
				sh_pos++;
				if (sh_pos >= nf) begin
					v = sh_csum + longint'(sh_weight[NFEAT]) * 256;
					ow = '0;
					ow.kind = KIND_CLASS;
					ow.class_positive = (v >= 0);
					ow.last = 1'b1;
					pending_words.push_back(ow);
					class_results++;
					sh_csum = 0;
					sh_pos = 0;
				end
			end
			default: begin
				sh_count = 0;
				sh_pos = 0;
				sh_csum = 0;
			end
		endcase
	endtask

	// True when this load would close a sample that has a never-written feature,
	// which happens after classify words moved the shared position on.
	function automatic bit load_leaves_hole();
		int nf;
		int p;
		nf = active_features();
		if (sh_count >= NSAMP) return 1'b0;
		p = (sh_pos >= nf) ? nf - 1 : sh_pos;
		if (p + 1 < nf) return 1'b0;
		for (int j = 0; j < nf; j++)
			if (j != p && !sh_written[sh_count][j]) return 1'b1;
		return 1'b0;
	endfunction

	// Presents one word, holds it until accepted, then maybe idles a while.
	task automatic send_raw(in_word_t w);
		int gap;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_word <= w;
		do @(posedge clk); while (sample_stall);
		predict_word(w);
		words_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			sample_valid <= 1'b0;
			sample_word <= in_word_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_word(in_word_t w);
		in_word_t c;
		if (w.command == CMD_LOAD && load_leaves_hole()) begin
			c = '0;
			c.command = CMD_CLEAR;
			send_raw(c);
		end
		send_raw(w);
	endtask

	function automatic in_word_t make_word(logic [1:0] cmd, logic [15:0] x, logic lab);
		in_word_t w;
		w.command = cmd;
		w.feature_value = x;
		w.label_positive = lab;
		return w;
	endfunction

	// Waits until every queued result has arrived and the pipe has settled.
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_FEATURE_COUNT: sh_feature_count = data[3:0];
			CFG_LEARN_RATE:    sh_learn_rate = data;
			CFG_MAX_PASSES:    sh_max_passes = data;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick_feature();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	// Result side: bursts of stall between stretches of free flow.
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
				@(negedge clk);
				result_stall <= 1'b0;
			end
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	end

	task automatic flag_field(string name, longint e, longint a);
		$display("%0t mismatch on %s: expected %0d, actual %0d", $realtime, name, e, a);
		errors++;
	endtask

	// Every result word is checked against the oldest one the predictor queued.
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected result word %h", $realtime, result_word);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (result_word.kind !== e.kind)
					flag_field("kind", e.kind, result_word.kind);
				if (result_word.weight_value !== e.weight_value)
					flag_field("weight_value", e.weight_value, result_word.weight_value);
				if (result_word.class_positive !== e.class_positive)
					flag_field("class_positive", e.class_positive, result_word.class_positive);
				if (result_word.converged !== e.converged)
					flag_field("converged", e.converged, result_word.converged);
				if (result_word.last !== e.last)
					flag_field("last", e.last, result_word.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d words outstanding", $realtime,
				pending_words.size());
			$display("perceptron_trainer regression: fail");
			$finish;
		end
	end

	// Directed table: a row is either a register write or an input word, and a
	// classify row may carry a typed-in expectation in place of the predictor's.
	typedef struct {
		bit          is_reg;
		logic [1:0]  idx;
		logic [15:0] data;
		logic [1:0]  cmd;
		logic        lab;
		bit          typed;
		out_word_t   typed_word;
	} step_row_t;

	localparam out_word_t CLASS_POS = '{kind: KIND_CLASS, weight_value: 32'sd0,
		class_positive: 1'b1, converged: 1'b0, last: 1'b1};

	step_row_t plan [] = '{
		// Zero weights after reset classify everything as positive.
		'{0, 0, 16'h7fff, CMD_CLASSIFY, 0, 0, '0},
		'{0, 0, 16'h8000, CMD_CLASSIFY, 0, 1, CLASS_POS},
		// Training with an empty store converges at once.
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0},
		// A feature count of zero behaves as one.
		'{1, CFG_FEATURE_COUNT, 16'h0000, 0, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_CLEAR, 0, 0, '0},
		'{0, 0, 16'h7fff, CMD_LOAD, 1, 0, '0},
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0},
		'{0, 0, 16'h8000, CMD_CLASSIFY, 0, 0, '0},
		// Largest rate and pass limit on a single sample.
		'{1, CFG_LEARN_RATE, 16'hffff, 0, 0, 0, '0},
		'{1, CFG_MAX_PASSES, 16'hffff, 0, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0},
		'{0, 0, 16'h8000, CMD_LOAD, 0, 0, '0},
		'{1, CFG_MAX_PASSES, 16'h0000, 0, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0},
		// Feature counts above the maximum clamp to eight.
		'{1, CFG_FEATURE_COUNT, 16'h000f, 0, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_CLEAR, 0, 0, '0},
		'{0, 0, 16'h7fff, CMD_LOAD, 0, 0, '0},
		'{0, 0, 16'h8000, CMD_LOAD, 1, 0, '0},
		'{0, 0, 16'h0001, CMD_LOAD, 0, 0, '0},
		'{0, 0, 16'hffff, CMD_LOAD, 1, 0, '0},
		'{0, 0, 16'h0100, CMD_LOAD, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_LOAD, 1, 0, '0},
		'{0, 0, 16'h7fff, CMD_LOAD, 0, 0, '0},
		'{0, 0, 16'h8000, CMD_LOAD, 1, 0, '0},
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0},
		// A zero rate never moves the weights.
		'{1, CFG_LEARN_RATE, 16'h0000, 0, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0},
		// Shared position: a classify word finishes a partial load, and a
		// train word drops a partial load; a write past the list is ignored.
		'{1, CFG_FEATURE_COUNT, 16'h0002, 0, 0, 0, '0},
		'{1, 2'd3, 16'hffff, 0, 0, 0, '0},
		'{1, CFG_LEARN_RATE, 16'h0100, 0, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_CLEAR, 0, 0, '0},
		'{0, 0, 16'h0200, CMD_LOAD, 1, 0, '0},
		'{0, 0, 16'h0100, CMD_CLASSIFY, 0, 0, '0},
		'{0, 0, 16'h0300, CMD_LOAD, 0, 0, '0},
		'{0, 0, 16'h0000, CMD_TRAIN, 0, 0, '0}
	};

	initial begin
		int nf;
		int nsamp;
		int ncls;
		int rand_words;
		logic [15:0] fcv;
		logic [15:0] lrv;
		logic [1:0] ncmd;

		for (int j = 0; j <= NFEAT; j++) sh_weight[j] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_word(make_word(plan[i].cmd, plan[i].data, plan[i].lab));
				if (plan[i].typed) begin
					void'(pending_words.pop_back());
					pending_words.push_back(plan[i].typed_word);
				end
			end
		end

		// Store full: loads past the last slot are ignored; one pass over it.
		drain();
		write_reg(CFG_FEATURE_COUNT, 16'd1);
		write_reg(CFG_MAX_PASSES, 16'd0);
		send_word(make_word(CMD_CLEAR, 16'h0, 1'b0));
		for (int i = 0; i < NSAMP + 3; i++)
			send_word(make_word(CMD_LOAD, pick_feature(), 1'($urandom)));
		send_word(make_word(CMD_TRAIN, 16'h0, 1'b0));

		// Random phases: small sample sets, a train, then classify vectors, with
		// stray words mixed in. The last stretch runs without any idling.
		rand_words = words_sent;
		while (words_sent - rand_words < RANDOM_ITEMS) begin
			drain();
			quiet = (words_sent - rand_words > RANDOM_ITEMS - 25);
			case ($urandom_range(0, 5))
				0: fcv = 16'd0;
				1: fcv = 16'($urandom_range(9, 15));
				2: fcv = 16'd8;
				default: fcv = 16'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 4))
				0: lrv = 16'hffff;
				1: lrv = 16'($urandom);
				2: lrv = 16'($urandom_range(0, 16));
				default: lrv = 16'h0100;
			endcase
			write_reg(CFG_FEATURE_COUNT, fcv);
			write_reg(CFG_LEARN_RATE, lrv);
			write_reg(CFG_MAX_PASSES, ($urandom_range(0, 3) == 0) ? 16'd0
				: 16'($urandom_range(1, 30)));
			send_word(make_word(CMD_CLEAR, 16'h0, 1'($urandom)));
			nf = active_features();
			nsamp = $urandom_range(0, 6);
			for (int s = 0; s < nsamp * nf; s++) begin
				if ($urandom_range(0, 11) == 0) begin
					ncmd = 2'($urandom);
					if (ncmd == CMD_LOAD && sh_count >= 7) ncmd = CMD_CLEAR;
					send_word(make_word(ncmd, pick_feature(), 1'($urandom)));
				end
				if (sh_count < 8)
					send_word(make_word(CMD_LOAD, pick_feature(), 1'($urandom)));
			end
			send_word(make_word(CMD_TRAIN, 16'($urandom), 1'($urandom)));
			ncls = $urandom_range(1, 3);
			for (int s = 0; s < ncls * nf; s++) begin
				if ($urandom_range(0, 15) == 0 && sh_count < 8)
					send_word(make_word(CMD_LOAD, pick_feature(), 1'($urandom)));
				send_word(make_word(CMD_CLASSIFY, pick_feature(), 1'($urandom)));
			end
		end

		drain();
		repeat (30) @(posedge clk);
		$display("Sent %0d words: %0d training runs and %0d classifications checked,",
			words_sent, train_runs, class_results);
		$display("including a full sample store and clamped feature counts; %0d errors.",
			errors);
		if (errors == 0 && pending_words.size() == 0)
			$display("perceptron_trainer regression: pass");
		else
			$display("perceptron_trainer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
